// ===== design/chm_pkg.sv =====
// shared constants and status codes for the chained hash map engine
package chm_pkg;

    localparam int POOL_ENTRIES = 1024;
    localparam int MAX_BUCKETS  = 256;
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = IDX_W + 1;
    localparam int BKT_W        = $clog2(MAX_BUCKETS);
    localparam int LOG2_W       = 4;

    localparam logic [31:0]       HASH_MULTIPLIER = 32'd2654435769;
    localparam logic [LINK_W-1:0] NIL_LINK        = {LINK_W{1'b1}};
    localparam logic [LOG2_W-1:0] INITIAL_LOG2    = LOG2_W'(2);
    localparam logic [LOG2_W-1:0] MAX_LOG2        = LOG2_W'(BKT_W);
    localparam logic [LINK_W-1:0] POOL_FULL_COUNT = LINK_W'(POOL_ENTRIES);

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_POOL_FULL = 3'd4;

    // transaction kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

endpackage

// ===== design/chained_hash_map_engine.sv =====
// chained hash map engine: sequencer, head and entry memories, shared hash multiplier
// an accepted transaction is hashed, its bucket head read and its chain walked, then the result register is loaded
// growth re-links every entry of each old bucket into the two new buckets before the lookup
// throughput: one transaction at a time, set by the chain walk over the single entry port
// a new transaction is taken while the previous result waits in the output register
// reset: all buckets empty (per-bucket valid flops), count zero, four buckets
module chained_hash_map_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] stored_value,
    output logic [7:0]  bucket
);

    localparam int LW = chm_pkg::LINK_W;
    localparam int IW = chm_pkg::IDX_W;
    localparam int BW = chm_pkg::BKT_W;
    localparam int GW = chm_pkg::LOG2_W;

    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_G_HEAD = 4'd1;
    localparam logic [3:0] S_G_HRD  = 4'd2;
    localparam logic [3:0] S_G_ENT  = 4'd3;
    localparam logic [3:0] S_G_MUL  = 4'd4;
    localparam logic [3:0] S_G_PUSH = 4'd5;
    localparam logic [3:0] S_G_WB0  = 4'd6;
    localparam logic [3:0] S_G_WB1  = 4'd7;
    localparam logic [3:0] S_HASH   = 4'd8;
    localparam logic [3:0] S_BKT    = 4'd9;
    localparam logic [3:0] S_F_HEAD = 4'd10;
    localparam logic [3:0] S_F_CHK  = 4'd11;
    localparam logic [3:0] S_F_CMP  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic          kind_reg;
    logic [31:0]   key_reg, value_reg;
    logic [GW-1:0] log2_reg, log2_next;
    logic [LW-1:0] count_reg, count_next;
    logic [BW-1:0] idx_reg, idx_next;
    logic [LW-1:0] e_reg, e_next;
    logic [LW-1:0] nxt_reg, nxt_next;
    logic [LW-1:0] h0_reg, h0_next, h1_reg, h1_next;
    logic [LW-1:0] head_reg, head_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [31:0]   prod_reg;
    logic [2:0]    res_st_reg, res_st_next;
    logic [31:0]   res_val_reg, res_val_next;

    logic          out_valid_reg;
    logic [2:0]    out_st_reg;
    logic [31:0]   out_val_reg;
    logic [7:0]    out_bkt_reg;

    // bucket head memory with per-bucket valid flops
    logic [LW-1:0]          heads_mem [chm_pkg::MAX_BUCKETS];
    logic [chm_pkg::MAX_BUCKETS-1:0] hvalid_reg;
    logic [BW-1:0]          h_raddr, h_waddr;
    logic [LW-1:0]          h_wdata, h_rdata_reg;
    logic                   h_we, h_rvld_reg;

    // entry pool memories
    logic [31:0]   keys_mem   [chm_pkg::POOL_ENTRIES];
    logic [31:0]   values_mem [chm_pkg::POOL_ENTRIES];
    logic [LW-1:0] links_mem  [chm_pkg::POOL_ENTRIES];
    logic [IW-1:0] e_raddr, e_waddr;
    logic [31:0]   key_rd_reg, val_rd_reg;
    logic [LW-1:0] link_rd_reg;
    logic          key_we, val_we, link_we;
    logic [31:0]   val_wdata;
    logic [LW-1:0] link_wdata;

    // shared multiplier operand and derived hash bits
    logic [31:0]   mul_op;
    logic [31:0]   mul_lo;
    logic [BW-1:0] hash_bkt;
    logic          split_bit;
    logic          out_free;
    logic [LW-1:0] head_now;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_st_reg;
    assign stored_value = out_val_reg;
    assign bucket       = out_bkt_reg;
    assign out_free     = !out_valid_reg || out_ready;

    assign mul_op    = (state_reg == S_HASH) ? key_reg : key_rd_reg;
    assign mul_lo    = mul_op * chm_pkg::HASH_MULTIPLIER;
    assign hash_bkt  = BW'(prod_reg[31:32-BW] >> (GW'(BW) - log2_reg));
    assign split_bit = prod_reg[5'(6'd32 - 6'(log2_reg))];
    assign head_now  = h_rvld_reg ? h_rdata_reg : chm_pkg::NIL_LINK;

    // head memory ports
    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            heads_mem[h_waddr] <= h_wdata;
        end
        h_rdata_reg <= heads_mem[h_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= '0;
            h_rvld_reg <= 1'b0;
        end
        else
        begin
            if (h_we)
            begin
                hvalid_reg[h_waddr] <= 1'b1;
            end
            h_rvld_reg <= hvalid_reg[h_raddr];
        end
    end

    // entry memory ports
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            keys_mem[e_waddr] <= key_reg;
        end
        if (val_we)
        begin
            values_mem[e_waddr] <= val_wdata;
        end
        if (link_we)
        begin
            links_mem[e_waddr] <= link_wdata;
        end
        key_rd_reg  <= keys_mem[e_raddr];
        val_rd_reg  <= values_mem[e_raddr];
        link_rd_reg <= links_mem[e_raddr];
    end

    // multiplier result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_HASH || state_reg == S_G_MUL)
        begin
            prod_reg <= mul_lo;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        log2_next    = log2_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        e_next       = e_reg;
        nxt_next     = nxt_reg;
        h0_next      = h0_reg;
        h1_next      = h1_reg;
        head_next    = head_reg;
        bkt_next     = bkt_reg;
        res_st_next  = res_st_reg;
        res_val_next = res_val_reg;
        h_raddr      = idx_reg;
        h_waddr      = bkt_reg;
        h_wdata      = h0_reg;
        h_we         = 1'b0;
        e_raddr      = e_reg[IW-1:0];
        e_waddr      = e_reg[IW-1:0];
        key_we       = 1'b0;
        val_we       = 1'b0;
        link_we      = 1'b0;
        val_wdata    = value_reg;
        link_wdata   = head_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == chm_pkg::KIND_INSERT && log2_reg < chm_pkg::MAX_LOG2
                        && count_reg >= (LW'(3) << log2_reg))
                    begin
                        idx_next   = BW'((9'd1 << log2_reg) - 9'd1);
                        log2_next  = log2_reg + GW'(1);
                        state_next = S_G_HEAD;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_G_HEAD:
            begin
                state_next = S_G_HRD;
            end
            S_G_HRD:
            begin
                e_next     = head_now;
                h0_next    = chm_pkg::NIL_LINK;
                h1_next    = chm_pkg::NIL_LINK;
                state_next = S_G_ENT;
            end
            S_G_ENT:
            begin
                state_next = e_reg[IW] ? S_G_WB0 : S_G_MUL;
            end
            S_G_MUL:
            begin
                nxt_next   = link_rd_reg;
                state_next = S_G_PUSH;
            end
            S_G_PUSH:
            begin
                // push entry at the head of its new bucket
                link_we    = 1'b1;
                link_wdata = split_bit ? h1_reg : h0_reg;
                if (split_bit)
                begin
                    h1_next = e_reg;
                end
                else
                begin
                    h0_next = e_reg;
                end
                e_next     = nxt_reg;
                state_next = S_G_ENT;
            end
            S_G_WB0:
            begin
                h_we       = 1'b1;
                h_waddr    = {idx_reg[BW-2:0], 1'b0};
                h_wdata    = h0_reg;
                state_next = S_G_WB1;
            end
            S_G_WB1:
            begin
                h_we    = 1'b1;
                h_waddr = {idx_reg[BW-2:0], 1'b1};
                h_wdata = h1_reg;
                if (idx_reg == '0)
                begin
                    state_next = S_HASH;
                end
                else
                begin
                    idx_next   = idx_reg - BW'(1);
                    state_next = S_G_HEAD;
                end
            end
            S_HASH:
            begin
                state_next = S_BKT;
            end
            S_BKT:
            begin
                bkt_next   = hash_bkt;
                h_raddr    = hash_bkt;
                state_next = S_F_HEAD;
            end
            S_F_HEAD:
            begin
                e_next     = head_now;
                head_next  = head_now;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (e_reg[IW])
                begin
                    res_val_next = '0;
                    if (kind_reg == chm_pkg::KIND_SEARCH)
                    begin
                        res_st_next = chm_pkg::ST_NOT_FOUND;
                    end
                    else if (count_reg == chm_pkg::POOL_FULL_COUNT)
                    begin
                        res_st_next = chm_pkg::ST_POOL_FULL;
                    end
                    else
                    begin
                        res_st_next = chm_pkg::ST_INSERTED;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_F_CMP;
                end
            end
            S_F_CMP:
            begin
                if (key_rd_reg == key_reg)
                begin
                    if (kind_reg == chm_pkg::KIND_SEARCH)
                    begin
                        res_st_next  = chm_pkg::ST_FOUND;
                        res_val_next = val_rd_reg;
                    end
                    else
                    begin
                        res_st_next  = chm_pkg::ST_UPDATED;
                        res_val_next = '0;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    e_next     = link_rd_reg;
                    state_next = S_F_CHK;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    // commit table changes with the result
                    if (res_st_reg == chm_pkg::ST_UPDATED)
                    begin
                        val_we = 1'b1;
                    end
                    else if (res_st_reg == chm_pkg::ST_INSERTED)
                    begin
                        e_waddr    = count_reg[IW-1:0];
                        key_we     = 1'b1;
                        val_we     = 1'b1;
                        link_we    = 1'b1;
                        h_we       = 1'b1;
                        h_wdata    = count_reg;
                        count_next = count_reg + LW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            log2_reg      <= chm_pkg::INITIAL_LOG2;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            log2_reg  <= log2_next;
            count_reg <= count_next;
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= kind;
            key_reg   <= key;
            value_reg <= value;
        end
        idx_reg     <= idx_next;
        e_reg       <= e_next;
        nxt_reg     <= nxt_next;
        h0_reg      <= h0_next;
        h1_reg      <= h1_next;
        head_reg    <= head_next;
        bkt_reg     <= bkt_next;
        res_st_reg  <= res_st_next;
        res_val_reg <= res_val_next;
        if (state_reg == S_OUT && out_free)
        begin
            out_st_reg  <= res_st_reg;
            out_val_reg <= res_val_reg;
            out_bkt_reg <= 8'(bkt_reg);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= chm_pkg::POOL_FULL_COUNT)
        else $error("entry count beyond pool size");

    a_log2_range: assert property (@(posedge clk) disable iff (!rst_n)
        log2_reg >= chm_pkg::INITIAL_LOG2 && log2_reg <= chm_pkg::MAX_LOG2)
        else $error("bucket count out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("sequencer did not start on accepted transaction");

    a_result_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_st_reg != chm_pkg::ST_FOUND |-> out_val_reg == '0)
        else $error("stored value nonzero without a hit");
`endif

endmodule

// ===== tb/chained_hash_map_checker.sv =====
// checker for the chained hash map engine: shadow table, expected results and compare
module chained_hash_map_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [31:0] stored_value,
    input  logic [7:0]  bucket,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] stored_value;
        logic [7:0]  bucket;
    } map_result_t;

    // shadow table
    int          heads [chm_pkg::MAX_BUCKETS];
    logic [31:0] keys_mem [chm_pkg::POOL_ENTRIES];
    logic [31:0] vals_mem [chm_pkg::POOL_ENTRIES];
    int          links_mem [chm_pkg::POOL_ENTRIES];
    int          n_entries;
    int          log2_buckets;
    map_result_t expected_q[$];

    function automatic int hash_of(logic [31:0] k, int lg);
        logic [31:0] frac;
        frac = k * chm_pkg::HASH_MULTIPLIER;
        if (lg == 0)
            return 0;
        return int'(frac >> (32 - lg));
    endfunction

    function automatic int lookup(logic [31:0] k, int b);
        int e;
        int steps;
        e = heads[b];
        steps = 0;
        while (e >= 0 && steps <= n_entries) begin
            if (keys_mem[e] == k)
                return e;
            e = links_mem[e];
            steps++;
        end
        return -1;
    endfunction

    // double the buckets once load reaches three per bucket, up to the maximum bucket count
    task automatic grow_table();
        int old_n;
        int fresh [chm_pkg::MAX_BUCKETS];
        int e;
        int nxt;
        int nb;
        old_n = 1 << log2_buckets;
        if (n_entries < 3 * old_n || old_n * 2 > chm_pkg::MAX_BUCKETS)
            return;
        log2_buckets++;
        foreach (fresh[i])
            fresh[i] = -1;
        for (int i = 0; i < old_n; i++)
        begin
            e = heads[i];
            while (e >= 0)
            begin
                nxt = links_mem[e];
                nb = hash_of(keys_mem[e], log2_buckets);
                links_mem[e] = fresh[nb];
                fresh[nb] = e;
                e = nxt;
            end
        end
        heads = fresh;
    endtask

    task automatic predict_map_op(logic k_kind, logic [31:0] k, logic [31:0] v);
        map_result_t r;
        int b;
        int e;
        r.stored_value = '0;
        if (k_kind == chm_pkg::KIND_INSERT)
        begin
            grow_table();
            b = hash_of(k, log2_buckets);
            e = lookup(k, b);
            if (e >= 0)
            begin
                vals_mem[e] = v;
                r.status = chm_pkg::ST_UPDATED;
            end
            else if (n_entries >= chm_pkg::POOL_ENTRIES)
                r.status = chm_pkg::ST_POOL_FULL;
            else
            begin
                keys_mem[n_entries] = k;
                vals_mem[n_entries] = v;
                links_mem[n_entries] = heads[b];
                heads[b] = n_entries;
                n_entries++;
                r.status = chm_pkg::ST_INSERTED;
            end
        end
        else
        begin
            b = hash_of(k, log2_buckets);
            e = lookup(k, b);
            if (e >= 0)
            begin
                r.status = chm_pkg::ST_FOUND;
                r.stored_value = vals_mem[e];
            end
            else
                r.status = chm_pkg::ST_NOT_FOUND;
        end
        r.bucket = b[7:0];
        expected_q.push_back(r);
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        map_result_t want;
        if (!rst_n)
        begin
            foreach (heads[i])
                heads[i] = -1;
            n_entries = 0;
            log2_buckets = 2;
            expected_q.delete();
            fail_count = 0;
            results_seen = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_map_op(kind, key, value);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d value=%h bucket=%0d",
                             $time, status, stored_value, bucket);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        fail_count++;
                    end
                    if (stored_value !== want.stored_value)
                    begin
                        $display("%0t: stored_value expected %h actual %h",
                                 $time, want.stored_value, stored_value);
                        fail_count++;
                    end
                    if (bucket !== want.bucket)
                    begin
                        $display("%0t: bucket expected %0d actual %0d",
                                 $time, want.bucket, bucket);
                        fail_count++;
                    end
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

// ===== tb/chained_hash_map_engine_test.sv =====
// top of the chained hash map engine testbench: stimulus, stall pattern and verdict
module chained_hash_map_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = chm_pkg::KIND_INSERT;
    logic [31:0] key = '0;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] stored_value;
    logic [7:0]  bucket;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          idle_cycles = 0;
    int          ops_sent = 0;
    bit          hold_off = 1'b0;
    logic [31:0] used_keys[$];

    always #2 clk = ~clk;

    chained_hash_map_engine u_top (.*);

    chained_hash_map_checker u_check (.*);

    // one transaction on the input channel
    task automatic send_op(logic k_kind, logic [31:0] k, logic [31:0] v);
        int gap;
        gap = $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k_kind;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        ops_sent++;
        if (k_kind == chm_pkg::KIND_INSERT)
            used_keys.push_back(k);
    endtask

    function automatic logic [31:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return $urandom();
    endfunction

    // receiver: random stalls, one long hold-off
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                stall = 400;
                hold_off = 1'b0;
            end
            else
            begin
                stall = $urandom_range(0, 14);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // watchdog on accepted transactions
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty search, extremes, update, found and not found
        send_op(chm_pkg::KIND_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(chm_pkg::KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(chm_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(chm_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_op(chm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(chm_pkg::KIND_INSERT, 32'h8000_0000, 32'h1234_5678);
        send_op(chm_pkg::KIND_SEARCH, 32'h8000_0000, 32'h0);
        send_op(chm_pkg::KIND_SEARCH, 32'h7FFF_FFFF, 32'h0);
        send_op(chm_pkg::KIND_SEARCH, 32'hFFFF_FFFF, 32'h0);
        send_op(chm_pkg::KIND_SEARCH, 32'h0000_0001, 32'h0);
        // long receiver stall while inserts keep coming
        hold_off = 1'b1;
        for (int i = 0; i < 14; i++)
            send_op(chm_pkg::KIND_INSERT, $urandom(), $urandom());

        // random mix; mostly fresh inserts so the pool fills and growth reaches its cap
        for (int i = 0; i < 1505; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                send_op(chm_pkg::KIND_INSERT,
                        ($urandom_range(0, 9) == 0) ? pick_key() : $urandom(), $urandom());
            else
                send_op(chm_pkg::KIND_SEARCH, pick_key(), $urandom());
        end
        // updates and searches once the pool is full
        for (int i = 0; i < 20; i++)
            send_op(i[0] ? chm_pkg::KIND_SEARCH : chm_pkg::KIND_INSERT, pick_key(), $urandom());
        send_op(chm_pkg::KIND_INSERT, $urandom(), $urandom());
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d transactions, %0d results checked, up to a full pool",
                 ops_sent, results_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
